FILE: src/apu_pkg.sv
// Shared constants and types for the active particle update block.
package apu_pkg;

    localparam int POSITION_BITS = 32;
    localparam int ANGLE_BITS    = 16;

    localparam int NOISE_W = 16;
    localparam int STEP_W  = 24;
    localparam int GAIN_W  = 16;
    localparam int BOX_W   = 31;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(655);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);
    localparam logic [BOX_W-1:0]  BOX_RESET  = BOX_W'(6553600);

    // sine magnitude: unsigned Q16 in 0..65536
    localparam int TRIG_W = 17;
    localparam logic [TRIG_W-1:0] TRIG_ONE = TRIG_W'(65536);
    localparam logic [TRIG_W-1:0] POLY_A   = TRIG_W'(102944);
    localparam logic [TRIG_W-1:0] POLY_B   = TRIG_W'(42048);
    localparam logic [TRIG_W-1:0] POLY_C   = TRIG_W'(4640);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LENGTH = 2'd0,
        CFG_NOISE_GAIN  = 2'd1,
        CFG_BOX_WIDTH   = 2'd2,
        CFG_BOX_HEIGHT  = 2'd3
    } t_cfg_idx;

endpackage

FILE: src/apu_in_if.sv
// Particle input channel: valid, ready and one particle word.
interface apu_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [apu_pkg::POSITION_BITS-1:0] position_x;
    logic signed [apu_pkg::POSITION_BITS-1:0] position_y;
    logic [apu_pkg::ANGLE_BITS-1:0]           heading;
    logic signed [apu_pkg::NOISE_W-1:0]       noise_sample;
    logic                                     last_in_sweep;

    modport source (
        output valid, position_x, position_y, heading, noise_sample, last_in_sweep,
        input  ready
    );
    modport sink (
        input  valid, position_x, position_y, heading, noise_sample, last_in_sweep,
        output ready
    );
endinterface

FILE: src/apu_out_if.sv
// Particle result channel: valid, ready and one updated particle word.
interface apu_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [apu_pkg::POSITION_BITS-1:0] new_x;
    logic signed [apu_pkg::POSITION_BITS-1:0] new_y;
    logic [apu_pkg::ANGLE_BITS-1:0]           new_heading;
    logic                                     sweep_done;

    modport source (
        output valid, new_x, new_y, new_heading, sweep_done,
        input  ready
    );
    modport sink (
        input  valid, new_x, new_y, new_heading, sweep_done,
        output ready
    );
endinterface

FILE: src/apu_sine.sv
// Four-stage quarter-wave sine polynomial, Horner form, one product per stage.
module apu_sine (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [apu_pkg::TRIG_W-1:0]       i_arg,
    output logic [apu_pkg::TRIG_W-1:0]       o_val
);

    localparam int TW = apu_pkg::TRIG_W;
    localparam int PW = 2 * TW;

    logic [TW-1:0] r1_arg, r1_z2;
    logic [TW-1:0] r2_arg, r2_z2, r2_t;
    logic [TW-1:0] r3_arg, r3_t;
    logic [TW-1:0] r4_val;

    logic [PW-1:0] n_sq, n_cz, n_tz, n_ta;
    logic [TW-1:0] n_z2, n_t2, n_t3, n_val;
    logic [PW-17:0] n_hi;

    always_comb begin
        n_sq  = PW'(i_arg) * PW'(i_arg);
        n_z2  = n_sq[TW+15:16];
        n_cz  = PW'(apu_pkg::POLY_C) * PW'(r1_z2);
        n_t2  = apu_pkg::POLY_B - n_cz[TW+15:16];
        n_tz  = PW'(r2_t) * PW'(r2_z2);
        n_t3  = apu_pkg::POLY_A - n_tz[TW+15:16];
        n_ta  = PW'(r3_t) * PW'(r3_arg);
        n_hi  = n_ta[PW-1:16];
        n_val = (n_hi > (PW-16)'(apu_pkg::TRIG_ONE)) ? apu_pkg::TRIG_ONE : n_hi[TW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_arg <= i_arg;
            r1_z2  <= n_z2;
            r2_arg <= r1_arg;
            r2_z2  <= r1_z2;
            r2_t   <= n_t2;
            r3_arg <= r2_arg;
            r3_t   <= n_t3;
            r4_val <= n_val;
        end
    end

    assign o_val = r4_val;

endmodule

FILE: src/active_particle_update.sv
// Top level: one Euler step of an active Brownian particle per word.
// A result word reaches the output through stage registers r0 to r7 after its input word is accepted.
// Throughput: one word per cycle; the eight-register pipeline advances whenever
// the output register is empty or being taken.
// Reset (synchronous, active low) empties the pipeline and loads the register
// defaults; configuration writes take effect at the next edge.
module active_particle_update (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    apu_in_if.sink                              i_in,
    apu_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [apu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [apu_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int PB      = apu_pkg::POSITION_BITS;
    localparam int AB      = apu_pkg::ANGLE_BITS;
    localparam int TW      = apu_pkg::TRIG_W;
    localparam int PROD_W  = apu_pkg::STEP_W + TW;
    localparam int DISP_W  = PROD_W - 16;
    localparam int SW      = ((PB > DISP_W) ? PB : DISP_W) + 2;
    localparam int FW      = ((PB > apu_pkg::BOX_W + 1) ? PB : apu_pkg::BOX_W + 1) + 2;
    localparam int ZSHL    = (AB <= 18) ? 18 - AB : 0;
    localparam int ZSHR    = (AB > 18) ? AB - 18 : 0;
    localparam int ZW      = AB + 8;
    localparam int NP_W    = apu_pkg::GAIN_W + apu_pkg::NOISE_W + 1;
    localparam int HW      = NP_W + AB;
    localparam int DEPTH   = 8;

    localparam logic signed [PB-1:0] POS_MAX = {1'b0, {(PB-1){1'b1}}};
    localparam logic signed [PB-1:0] POS_MIN = {1'b1, {(PB-1){1'b0}}};

    typedef struct packed {
        logic signed [PB-1:0] x;
        logic signed [PB-1:0] y;
        logic [AB-1:0]        hdg;
        logic                 last;
        logic                 sin_neg;
        logic                 cos_neg;
    } t_side;

    function automatic logic signed [PB-1:0] sat_pos(input logic signed [FW-1:0] v);
        logic signed [PB-1:0] r;
        if (v > FW'(POS_MAX)) begin
            r = POS_MAX;
        end else if (v < FW'(POS_MIN)) begin
            r = POS_MIN;
        end else begin
            r = v[PB-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [PB-1:0] add_sat(
        input logic signed [PB-1:0] p,
        input logic [DISP_W-1:0]    m,
        input logic                 neg
    );
        logic signed [SW-1:0] d;
        logic signed [SW-1:0] s;
        logic signed [PB-1:0] r;
        d = signed'(SW'(m));
        if (neg) begin
            d = -d;
        end
        s = SW'(p) + d;
        if (s > SW'(POS_MAX)) begin
            r = POS_MAX;
        end else if (s < SW'(POS_MIN)) begin
            r = POS_MIN;
        end else begin
            r = s[PB-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [PB-1:0] fold(
        input logic signed [PB-1:0]          p,
        input logic [apu_pkg::BOX_W-1:0]     box
    );
        logic signed [FW-1:0] pw;
        logic signed [FW-1:0] p2;
        logic signed [FW-1:0] b;
        logic signed [FW-1:0] r;
        pw = FW'(p);
        p2 = pw <<< 1;
        b  = signed'(FW'(box));
        if (p2 > b) begin
            r = pw - b;
        end else if (p2 < -b) begin
            r = pw + b;
        end else begin
            r = pw;
        end
        return sat_pos(r);
    endfunction

    // configuration
    logic [apu_pkg::STEP_W-1:0] r_step;
    logic [apu_pkg::GAIN_W-1:0] r_gain;
    logic [apu_pkg::BOX_W-1:0]  r_box_w;
    logic [apu_pkg::BOX_W-1:0]  r_box_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= apu_pkg::STEP_RESET;
            r_gain  <= apu_pkg::GAIN_RESET;
            r_box_w <= apu_pkg::BOX_RESET;
            r_box_h <= apu_pkg::BOX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                apu_pkg::CFG_STEP_LENGTH: r_step  <= i_cfg_data[apu_pkg::STEP_W-1:0];
                apu_pkg::CFG_NOISE_GAIN:  r_gain  <= i_cfg_data[apu_pkg::GAIN_W-1:0];
                apu_pkg::CFG_BOX_WIDTH:   r_box_w <= i_cfg_data[apu_pkg::BOX_W-1:0];
                apu_pkg::CFG_BOX_HEIGHT:  r_box_h <= i_cfg_data[apu_pkg::BOX_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [DEPTH-1:0] r_vld;
    logic             en;

    assign en          = !r_vld[DEPTH-1] || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in.valid};
        end
    end

    // stage registers
    logic signed [PB-1:0]                r0_x, r0_y;
    logic [AB-1:0]                       r0_h;
    logic signed [apu_pkg::NOISE_W-1:0]  r0_n;
    logic                                r0_last;

    t_side                   r1_side, r2_side, r3_side, r4_side, r5_side, r6_side;
    logic signed [NP_W-1:0]  r1_prod;
    logic [DISP_W-1:0]       r5_dx, r5_dy;
    logic signed [PB-1:0]    r6_px, r6_py;
    logic signed [PB-1:0]    r7_x, r7_y;
    logic [AB-1:0]           r7_h;
    logic                    r7_last;

    logic [1:0]              n_quad;
    logic [ZW-1:0]           n_zw;
    logic [TW-1:0]           n_z, n_sin_arg, n_cos_arg, sin_mag, cos_mag;
    logic signed [HW-1:0]    n_inc;
    logic [AB-1:0]           n_hdg;
    logic [PROD_W-1:0]       n_dx_p, n_dy_p;
    t_side                   n_side1;
    t_side                   n_side2;

    always_comb begin
        n_quad    = r0_h[AB-1 -: 2];
        n_zw      = (ZW'(r0_h[AB-3:0]) << ZSHL) >> ZSHR;
        n_z       = n_zw[TW-1:0];
        n_sin_arg = n_quad[0] ? apu_pkg::TRIG_ONE - n_z : n_z;
        n_cos_arg = n_quad[0] ? n_z : apu_pkg::TRIG_ONE - n_z;

        n_side1.x       = r0_x;
        n_side1.y       = r0_y;
        n_side1.hdg     = r0_h;
        n_side1.last    = r0_last;
        n_side1.sin_neg = n_quad[1];
        n_side1.cos_neg = n_quad[1] ^ n_quad[0];

        n_inc = HW'(r1_prod) >>> 12;
        n_hdg = r1_side.hdg + n_inc[AB-1:0];

        n_side2     = r1_side;
        n_side2.hdg = n_hdg;

        n_dx_p = PROD_W'(r_step) * PROD_W'(cos_mag) + PROD_W'(32768);
        n_dy_p = PROD_W'(r_step) * PROD_W'(sin_mag) + PROD_W'(32768);
    end

    apu_sine u_sin (
        .i_clk (i_clk),
        .i_en  (en),
        .i_arg (n_sin_arg),
        .o_val (sin_mag)
    );

    apu_sine u_cos (
        .i_clk (i_clk),
        .i_en  (en),
        .i_arg (n_cos_arg),
        .o_val (cos_mag)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_x    <= i_in.position_x;
            r0_y    <= i_in.position_y;
            r0_h    <= i_in.heading;
            r0_n    <= i_in.noise_sample;
            r0_last <= i_in.last_in_sweep;

            r1_side <= n_side1;
            r1_prod <= NP_W'(signed'({1'b0, r_gain})) * NP_W'(r0_n);

            r2_side <= n_side2;

            r3_side <= r2_side;
            r4_side <= r3_side;

            r5_side <= r4_side;
            r5_dx   <= n_dx_p[PROD_W-1:16];
            r5_dy   <= n_dy_p[PROD_W-1:16];

            r6_side <= r5_side;
            r6_px   <= add_sat(r5_side.x, r5_dx, r5_side.cos_neg);
            r6_py   <= add_sat(r5_side.y, r5_dy, r5_side.sin_neg);

            r7_x    <= fold(r6_px, r_box_w);
            r7_y    <= fold(r6_py, r_box_h);
            r7_h    <= r6_side.hdg;
            r7_last <= r6_side.last;
        end
    end

    assign o_out.new_x       = r7_x;
    assign o_out.new_y       = r7_y;
    assign o_out.new_heading = r7_h;
    assign o_out.sweep_done  = r7_last;

endmodule

FILE: src/apu_checker.sv
// Port-level checks for the particle update block, bound to the top level.
module apu_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [apu_pkg::POSITION_BITS-1:0] i_new_x,
    input logic signed [apu_pkg::POSITION_BITS-1:0] i_new_y,
    input logic [apu_pkg::ANGLE_BITS-1:0]      i_new_heading,
    input logic                                i_sweep_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_new_x) && $stable(i_new_y)
            && $stable(i_new_heading) && $stable(i_sweep_done))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output register");

endmodule

bind active_particle_update apu_checker u_apu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_new_x       (o_out.new_x),
    .i_new_y       (o_out.new_y),
    .i_new_heading (o_out.new_heading),
    .i_sweep_done  (o_out.sweep_done)
);
